// ===== hw/rtl/dcp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Distance constraint projection package
// Shared widths, pipeline positions, payload structs and the saturation helper.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int INDEX_WIDTH = 16;
  localparam logic [15:0] IDX_MASK = 16'((64'd1 << INDEX_WIDTH) - 64'd1);

  localparam logic [31:0] RDT2_RESET = 32'd921600;

  // Square root: 66-bit radicand, 34-bit root, one root bit per stage.
  localparam int RAD_W       = 66;
  localparam int ROOT_W      = 34;
  localparam int SQRT_STAGES = ROOT_W;
  localparam int REM_W       = RAD_W + 2;

  // Divider: numerator is a 32-bit value shifted up by 30, one quotient bit per stage.
  localparam int FRAC_W     = 30;
  localparam int NUM_W      = 32 + FRAC_W;
  localparam int DEN_W      = 49;
  localparam int QUO_W      = FRAC_W + 1;
  localparam int DIV_STAGES = QUO_W;

  localparam int CMAG_W = ROOT_W;
  localparam int MAG_W  = CMAG_W + 1;
  localparam int SUM_W  = 32 + MAG_W;

  // Positions in the pipeline, counted in register stages after acceptance.
  localparam int S_FRONT  = 3;
  localparam int S_RW     = S_FRONT + DIV_STAGES;
  localparam int S_D      = S_FRONT + SQRT_STAGES;
  localparam int S_U      = S_D + DIV_STAGES;
  localparam int CTX_LAST = S_U + 1;
  localparam int VLD_LAST = CTX_LAST + 1;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic [RAD_W-1:0] sum;
    logic [DEN_W-1:0] w;
    logic             wz;
    vec3_t            mag;
    logic [2:0]       neg;
  } front_t;

  typedef struct packed {
    logic [15:0]                idx0;
    logic [15:0]                idx1;
    vec3_t                      p0;
    vec3_t                      p1;
    logic [31:0]                w0;
    logic [31:0]                w1;
    logic [30:0]                rest;
    vec3_t                      mag;
    logic [2:0]                 neg;
    logic                       wz;
    logic [QUO_W-1:0]           r0;
    logic [QUO_W-1:0]           r1;
    logic [CMAG_W-1:0]          cmag;
    logic                       c_neg;
    logic                       dz;
    logic [MAG_W-1:0]           m0;
    logic [MAG_W-1:0]           m1;
    logic [2:0][MAG_W-1:0]      s0;
    logic [2:0][MAG_W-1:0]      s1;
  } ctx_t;

  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [31:0] res;
    if (v > $signed(SUM_W'(32'h7FFF_FFFF))) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -$signed(SUM_W'(33'h0_8000_0000))) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/distance_constraint_projection_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Distance constraint projection
// Projects one two-particle distance constraint per transaction in fixed point.
// ----------------------------------------------------------------------------
// The block takes one constraint transaction per clock while in_stall is low
// and returns one result transaction per constraint, in order. The result is
// presented from the output registers at the end of 70 register stages, whose
// depth is set by the chain of a 34-stage square root (one root bit per
// stage) followed by a 31-stage direction divider (one quotient bit per
// stage); the weight dividers run beside the square root.
// The whole pipeline advances together: while a finished result is stalled at
// the output, in_stall is raised and every stage holds its contents, so no
// transaction is lost or repeated. The compliance scale register is sampled
// by the first stage, so it should be written only while the pipeline is
// empty. When the total weight or the distance is zero, the positions are
// returned unchanged with out_skipped set. Corrected coordinates saturate to
// the signed 32-bit range.
// ----------------------------------------------------------------------------
module distance_constraint_projection_top import dcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_first_index,
  input  wire logic [15:0] in_second_index,
  input  wire logic [31:0] in_first_x,
  input  wire logic [31:0] in_first_y,
  input  wire logic [31:0] in_first_z,
  input  wire logic [31:0] in_second_x,
  input  wire logic [31:0] in_second_y,
  input  wire logic [31:0] in_second_z,
  input  wire logic [31:0] in_first_inv_mass,
  input  wire logic [31:0] in_second_inv_mass,
  input  wire logic [30:0] in_rest_length,
  input  wire logic [31:0] in_stiffness_compliance,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_first_index,
  output logic [15:0]      out_second_index,
  output logic [31:0]      out_new_first_x,
  output logic [31:0]      out_new_first_y,
  output logic [31:0]      out_new_first_z,
  output logic [31:0]      out_new_second_x,
  output logic [31:0]      out_new_second_y,
  output logic [31:0]      out_new_second_z,
  output logic             out_skipped
);

  // Global advance: the pipeline moves whenever the output stage is free or
  // its transaction is being taken.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Compliance scale register.
  logic [31:0] rdt2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdt2_r <= RDT2_RESET;
    end else if (cfg_wr_en) begin
      rdt2_r <= cfg_wr_data;
    end
  end

  // Valid bits travel beside the context line.
  logic [VLD_LAST:1] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLD_LAST-1:1], in_valid};
    end
  end
  assign out_valid = vld_r[VLD_LAST];

  // Context line: every transaction carries its operands and the partial
  // results that later stages need; each stage fills in its own fields.
  ctx_t ctx_r   [1:CTX_LAST];
  ctx_t ctx_nxt [1:CTX_LAST];

  vec3_t in_p0, in_p1;
  assign in_p0 = {in_first_z, in_first_y, in_first_x};
  assign in_p1 = {in_second_z, in_second_y, in_second_x};

  always_comb begin
    ctx_nxt[1]      = '0;
    ctx_nxt[1].idx0 = in_first_index;
    ctx_nxt[1].idx1 = in_second_index;
    ctx_nxt[1].p0   = in_p0;
    ctx_nxt[1].p1   = in_p1;
    ctx_nxt[1].w0   = in_first_inv_mass;
    ctx_nxt[1].w1   = in_second_inv_mass;
    ctx_nxt[1].rest = in_rest_length;
  end

  // Front end: differences, squared distance and total weight.
  front_t front_q;
  dcp_front u_front (
    .clk  (clk),
    .en   (en),
    .p0   (in_p0),
    .p1   (in_p1),
    .w0   (in_first_inv_mass),
    .w1   (in_second_inv_mass),
    .comp (in_stiffness_compliance),
    .rdt2 (rdt2_r),
    .q    (front_q)
  );

  // Distance and the two weight ratios start together after the front end.
  logic [ROOT_W-1:0] dlen;
  dcp_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (front_q.sum),
    .root (dlen)
  );

  logic [QUO_W-1:0] r0_q, r1_q;
  dcp_div u_div_w0 (
    .clk (clk),
    .en  (en),
    .num ({ctx_r[S_FRONT].w0, FRAC_W'(0)}),
    .den (front_q.w),
    .quo (r0_q)
  );
  dcp_div u_div_w1 (
    .clk (clk),
    .en  (en),
    .num ({ctx_r[S_FRONT].w1, FRAC_W'(0)}),
    .den (front_q.w),
    .quo (r1_q)
  );

  // Unit direction components, one divider per axis, started when the
  // distance is known.
  logic [2:0][QUO_W-1:0] u_q;
  for (genvar i = 0; i < 3; i++) begin : g_dir
    dcp_div u_div_dir (
      .clk (clk),
      .en  (en),
      .num ({ctx_r[S_D].mag[i], FRAC_W'(0)}),
      .den (DEN_W'(dlen)),
      .quo (u_q[i])
    );
  end

  for (genvar k = 2; k <= CTX_LAST; k++) begin : g_ctx
    if (k == S_FRONT + 1) begin : g_front
      always_comb begin
        ctx_nxt[k]     = ctx_r[k-1];
        ctx_nxt[k].mag = front_q.mag;
        ctx_nxt[k].neg = front_q.neg;
        ctx_nxt[k].wz  = front_q.wz;
      end
    end else if (k == S_RW + 1) begin : g_ratio
      always_comb begin
        ctx_nxt[k]    = ctx_r[k-1];
        ctx_nxt[k].r0 = r0_q;
        ctx_nxt[k].r1 = r1_q;
      end
    end else if (k == S_D + 1) begin : g_cmag
      // Constraint error C = d - rest, kept as sign and magnitude.
      logic c_neg;
      always_comb begin
        c_neg           = dlen < ROOT_W'(ctx_r[k-1].rest);
        ctx_nxt[k]       = ctx_r[k-1];
        ctx_nxt[k].c_neg = c_neg;
        ctx_nxt[k].cmag  = c_neg ? ROOT_W'(ctx_r[k-1].rest) - dlen
                                 : dlen - ROOT_W'(ctx_r[k-1].rest);
        ctx_nxt[k].dz    = (dlen == '0);
      end
    end else if (k == S_D + 2) begin : g_mult
      // Correction magnitude for each particle: |C| times its weight ratio.
      logic [CMAG_W+QUO_W-1:0] pm0, pm1;
      always_comb begin
        pm0           = (CMAG_W+QUO_W)'(ctx_r[k-1].cmag) * (CMAG_W+QUO_W)'(ctx_r[k-1].r0);
        pm1           = (CMAG_W+QUO_W)'(ctx_r[k-1].cmag) * (CMAG_W+QUO_W)'(ctx_r[k-1].r1);
        ctx_nxt[k]    = ctx_r[k-1];
        ctx_nxt[k].m0 = pm0[FRAC_W +: MAG_W];
        ctx_nxt[k].m1 = pm1[FRAC_W +: MAG_W];
      end
    end else if (k == S_U + 1) begin : g_step
      // Per-axis step: correction magnitude times the direction component.
      logic [2:0][MAG_W+QUO_W-1:0] ps0, ps1;
      always_comb begin
        ctx_nxt[k] = ctx_r[k-1];
        for (int i = 0; i < 3; i++) begin
          ps0[i] = (MAG_W+QUO_W)'(ctx_r[k-1].m0) * (MAG_W+QUO_W)'(u_q[i]);
          ps1[i] = (MAG_W+QUO_W)'(ctx_r[k-1].m1) * (MAG_W+QUO_W)'(u_q[i]);
          ctx_nxt[k].s0[i] = ps0[i][FRAC_W +: MAG_W];
          ctx_nxt[k].s1[i] = ps1[i][FRAC_W +: MAG_W];
        end
      end
    end else begin : g_copy
      assign ctx_nxt[k] = ctx_r[k-1];
    end
  end

  for (genvar k = 1; k <= CTX_LAST; k++) begin : g_ctx_reg
    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[k] <= ctx_nxt[k];
      end
    end
  end

  // Output stage: apply the signed steps and saturate, or pass the positions
  // through when the constraint is skipped.
  ctx_t        last;
  logic        skip;
  vec3_t       new0_nxt, new1_nxt;
  logic signed [SUM_W-1:0] a0, a1, st0, st1;
  logic        pos;

  assign last = ctx_r[CTX_LAST];
  assign skip = last.wz || last.dz;

  always_comb begin
    new0_nxt = last.p0;
    new1_nxt = last.p1;
    for (int i = 0; i < 3; i++) begin
      // The step is positive when C and the axis difference share a sign.
      pos = (last.c_neg == last.neg[i]);
      a0  = SUM_W'($signed(last.p0[i]));
      a1  = SUM_W'($signed(last.p1[i]));
      st0 = $signed(SUM_W'(last.s0[i]));
      st1 = $signed(SUM_W'(last.s1[i]));
      if (!skip) begin
        new0_nxt[i] = sat32(pos ? a0 - st0 : a0 + st0);
        new1_nxt[i] = sat32(pos ? a1 + st1 : a1 - st1);
      end
    end
  end

  vec3_t       new0_r, new1_r;
  logic [15:0] idx0_r, idx1_r;
  logic        skip_r;

  always_ff @(posedge clk) begin
    if (en) begin
      new0_r <= new0_nxt;
      new1_r <= new1_nxt;
      idx0_r <= last.idx0 & IDX_MASK;
      idx1_r <= last.idx1 & IDX_MASK;
      skip_r <= skip;
    end
  end

  assign out_first_index  = idx0_r;
  assign out_second_index = idx1_r;
  assign out_new_first_x  = new0_r[0];
  assign out_new_first_y  = new0_r[1];
  assign out_new_first_z  = new0_r[2];
  assign out_new_second_x = new1_r[0];
  assign out_new_second_y = new1_r[1];
  assign out_new_second_z = new1_r[2];
  assign out_skipped      = skip_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dcp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Distance constraint projection front end
// Three stages: differences and compliance product, squares and total weight,
// sum of squares.
// ----------------------------------------------------------------------------
module dcp_front import dcp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire vec3_t       p0,
  input  wire vec3_t       p1,
  input  wire logic [31:0] w0,
  input  wire logic [31:0] w1,
  input  wire logic [31:0] comp,
  input  wire logic [31:0] rdt2,
  output front_t           q
);

  vec3_t       mag1_r, mag2_r;
  logic [2:0]  neg1_r, neg2_r;
  logic [63:0] prod_r;
  logic [31:0] w0_r, w1_r;
  logic [2:0][63:0] sq_r;
  logic [DEN_W-1:0] wsum_r;
  front_t      q_r;

  logic [2:0][32:0] diff;
  vec3_t       mag1_nxt;
  logic [2:0]  neg1_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]     = {p0[i][31], p0[i]} - {p1[i][31], p1[i]};
      neg1_nxt[i] = diff[i][32];
      mag1_nxt[i] = neg1_nxt[i] ? 32'(-diff[i]) : diff[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r <= mag1_nxt;
      neg1_r <= neg1_nxt;
      prod_r <= 64'(comp) * 64'(rdt2);
      w0_r   <= w0;
      w1_r   <= w1;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(mag1_r[i]) * 64'(mag1_r[i]);
      end
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      wsum_r <= DEN_W'(w0_r) + DEN_W'(w1_r) + DEN_W'(prod_r[63:16]);
      q_r.sum <= RAD_W'(sq_r[0]) + RAD_W'(sq_r[1]) + RAD_W'(sq_r[2]);
      q_r.w   <= wsum_r;
      q_r.wz  <= (wsum_r == '0);
      q_r.mag <= mag2_r;
      q_r.neg <= neg2_r;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dcp_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module dcp_sqrt import dcp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [RAD_W-1:0]  rad,
  output logic      [ROOT_W-1:0] root
);

  logic [REM_W-1:0]  rem_r  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - k;
    logic [REM_W-1:0]  rem_in, trial, rem_nxt;
    logic [ROOT_W-1:0] root_in, root_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = REM_W'(rad);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // The root holds only bits above B, so the shifted root and the square
    // of the new bit do not overlap.
    always_comb begin
      trial    = (REM_W'(root_in) << (B + 1)) | (REM_W'(1) << (2 * B));
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = root_in | (ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/dcp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned floor division, one quotient bit per stage, for quotients that
// fit in QUO_W bits.
// ----------------------------------------------------------------------------
module dcp_div import dcp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [QUO_W-1:0] quo
);

  localparam int CMP_W = DEN_W + QUO_W;

  logic [NUM_W-1:0] rem_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int J = DIV_STAGES - 1 - k;
    logic [NUM_W-1:0] rem_in, rem_nxt;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in, quo_nxt;
    logic [CMP_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      trial   = CMP_W'(den_in) << J;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (CMP_W'(rem_in) >= trial) begin
        rem_nxt = rem_in - trial[NUM_W-1:0];
        quo_nxt = quo_in | (QUO_W'(1) << J);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_in;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule
`default_nettype wire
